/* hdl/bet_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Boundary edge toggle package
// Shared sizes, field widths and action codes of the boundary edge table.
// ----------------------------------------------------------------------------
package bet_pkg;

  localparam int EDGE_SLOTS  = 256;
  localparam int VERTEX_BITS = 16;

  localparam int ADDR_W  = $clog2(EDGE_SLOTS);
  localparam int COUNT_W = ADDR_W + 1;
  localparam int ENTRY_W = 2 * VERTEX_BITS;

  localparam int ACTION_W = 2;
  localparam int INDEX_W  = 8;
  localparam int CNT_OUT_W = 9;

  localparam int IN_FIELDS_W  = 3 * VERTEX_BITS + INDEX_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 2 * VERTEX_BITS + 1 + CNT_OUT_W + 1;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [ACTION_W-1:0] ACT_UPDATE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_READ   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

  typedef logic [VERTEX_BITS-1:0] vertex_t;
  typedef logic [COUNT_W-1:0]     count_t;

endpackage
`default_nettype wire

/* hdl/bet_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bet_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire                       clk,
  input  wire                       we,
  input  wire [$clog2(DEPTH)-1:0]   waddr,
  input  wire [WIDTH-1:0]           wdata,
  input  wire [$clog2(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* hdl/boundary_edge_toggle.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Boundary edge toggle
// Ordered table of boundary edges held in one RAM, toggled per triangle edge.
// ----------------------------------------------------------------------------
// An update handles the triangle's edges in turn: each scans the RAM one entry a
// cycle and a removal moves the tail down one entry a cycle through the same
// read and write ports. A read request waits for the RAM read data before
// its response; a clear or no-op request goes straight to the response.
// One request is in work at a time; the result register frees the input side.
// Reset empties the table (entry count to zero); the RAM itself is not cleared.
// ----------------------------------------------------------------------------
module boundary_edge_toggle (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_tvalid,
  output logic                            in_tready,
  // vertex_a, vertex_b, vertex_c, read_index
  input  wire [bet_pkg::IN_TDATA_W-1:0]   in_tdata,
  // action
  input  wire [bet_pkg::ACTION_W-1:0]     in_tuser,
  output logic                            out_tvalid,
  input  wire                             out_tready,
  // edge_first, edge_second, read_valid, entry_count, overflow, zero fill
  output logic [bet_pkg::OUT_TDATA_W-1:0] out_tdata
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SEARCH = 3'd1;
  localparam logic [2:0] ST_SHIFT  = 3'd2;
  localparam logic [2:0] ST_RDWAIT = 3'd3;
  localparam logic [2:0] ST_RESP   = 3'd4;

  localparam int VB = bet_pkg::VERTEX_BITS;

  logic [2:0]               state_r, state_nxt;
  bet_pkg::count_t          count_r, count_nxt;
  bet_pkg::count_t          ptr_r, ptr_nxt;
  bet_pkg::count_t          pend_idx_r, pend_idx_nxt;
  logic                     pend_v_r, pend_v_nxt;
  logic [1:0]               edge_sel_r, edge_sel_nxt;
  bet_pkg::vertex_t         va_r, vb_r, vc_r;
  logic                     ovf_r, ovf_nxt;
  bet_pkg::vertex_t         res_first_r, res_first_nxt;
  bet_pkg::vertex_t         res_second_r, res_second_nxt;
  logic                     res_valid_r, res_valid_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [bet_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic                     ram_we;
  logic [bet_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [bet_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;

  bet_pkg::vertex_t         p, q, e_first, e_second;
  logic                     match, accept;
  logic [bet_pkg::ACTION_W-1:0] in_action;
  bet_pkg::vertex_t         in_va, in_vb, in_vc;
  logic [bet_pkg::INDEX_W-1:0] in_index;

  bet_ram #(
    .WIDTH (bet_pkg::ENTRY_W),
    .DEPTH (bet_pkg::EDGE_SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_action = in_tuser;
  assign in_va     = in_tdata[VB-1:0];
  assign in_vb     = in_tdata[2*VB-1:VB];
  assign in_vc     = in_tdata[3*VB-1:2*VB];
  assign in_index  = in_tdata[3*VB+bet_pkg::INDEX_W-1:3*VB];

  assign in_tready  = (state_r == ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    unique case (edge_sel_r)
      2'd0: begin
        p = va_r;
        q = vb_r;
      end
      2'd1: begin
        p = vb_r;
        q = vc_r;
      end
      default: begin
        p = vc_r;
        q = va_r;
      end
    endcase
  end

  assign e_first  = ram_rdata[VB-1:0];
  assign e_second = ram_rdata[2*VB-1:VB];
  assign match    = ((e_first == p) && (e_second == q)) ||
                    ((e_first == q) && (e_second == p));

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    ptr_nxt        = ptr_r;
    pend_idx_nxt   = pend_idx_r;
    pend_v_nxt     = 1'b0;
    edge_sel_nxt   = edge_sel_r;
    ovf_nxt        = ovf_r;
    res_first_nxt  = res_first_r;
    res_second_nxt = res_second_r;
    res_valid_nxt  = res_valid_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    ram_we         = 1'b0;
    ram_waddr      = count_r[bet_pkg::ADDR_W-1:0];
    ram_wdata      = {q, p};
    ram_raddr      = ptr_r[bet_pkg::ADDR_W-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          res_first_nxt  = '0;
          res_second_nxt = '0;
          res_valid_nxt  = 1'b0;
          ovf_nxt        = 1'b0;
          ptr_nxt        = '0;
          edge_sel_nxt   = 2'd0;
          ram_raddr      = in_index[bet_pkg::ADDR_W-1:0];
          priority if (in_action == bet_pkg::ACT_UPDATE) begin
            state_nxt = ST_SEARCH;
          end else if (in_action == bet_pkg::ACT_READ) begin
            res_valid_nxt = (bet_pkg::count_t'(in_index) < count_r);
            state_nxt     = ST_RDWAIT;
          end else if (in_action == bet_pkg::ACT_CLEAR) begin
            count_nxt = '0;
            state_nxt = ST_RESP;
          end else begin
            state_nxt = ST_RESP;
          end
        end
      end
      ST_SEARCH: begin
        priority if (pend_v_r && match) begin
          ptr_nxt   = pend_idx_r + bet_pkg::count_t'(1);
          state_nxt = ST_SHIFT;
        end else if (ptr_r < count_r) begin
          pend_v_nxt   = 1'b1;
          pend_idx_nxt = ptr_r;
          ptr_nxt      = ptr_r + bet_pkg::count_t'(1);
        end else begin
          if (count_r == bet_pkg::count_t'(bet_pkg::EDGE_SLOTS)) begin
            ovf_nxt = 1'b1;
          end else begin
            ram_we    = 1'b1;
            count_nxt = count_r + bet_pkg::count_t'(1);
          end
          ptr_nxt      = '0;
          edge_sel_nxt = edge_sel_r + 2'd1;
          if (edge_sel_r == 2'd2) begin
            state_nxt = ST_RESP;
          end
        end
      end
      ST_SHIFT: begin
        if (pend_v_r) begin
          ram_we    = 1'b1;
          ram_waddr = pend_idx_r[bet_pkg::ADDR_W-1:0] - bet_pkg::ADDR_W'(1);
          ram_wdata = ram_rdata;
        end
        if (ptr_r < count_r) begin
          pend_v_nxt   = 1'b1;
          pend_idx_nxt = ptr_r;
          ptr_nxt      = ptr_r + bet_pkg::count_t'(1);
        end else begin
          count_nxt    = count_r - bet_pkg::count_t'(1);
          ptr_nxt      = '0;
          edge_sel_nxt = edge_sel_r + 2'd1;
          state_nxt    = (edge_sel_r == 2'd2) ? ST_RESP : ST_SEARCH;
        end
      end
      ST_RDWAIT: begin
        if (res_valid_r) begin
          res_first_nxt  = e_first;
          res_second_nxt = e_second;
        end
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = bet_pkg::OUT_TDATA_W'({ovf_r,
                                                 bet_pkg::CNT_OUT_W'(count_r),
                                                 res_valid_r, res_second_r,
                                                 res_first_r});
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r        <= ptr_nxt;
    pend_idx_r   <= pend_idx_nxt;
    edge_sel_r   <= edge_sel_nxt;
    ovf_r        <= ovf_nxt;
    res_first_r  <= res_first_nxt;
    res_second_r <= res_second_nxt;
    res_valid_r  <= res_valid_nxt;
    out_data_r   <= out_data_nxt;
    if (accept) begin
      va_r <= in_va;
      vb_r <= in_vb;
      vc_r <= in_vc;
    end
  end

endmodule
`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Boundary edge toggle testbench
// Drives triangle, read, clear and no-op requests into the edge table through
// the input stream, mirrors the table in a scoreboard and compares every
// result field by field. Random requests add fresh edges and also rebuild or
// cut existing ones, so that removals, shifts, a full table and dropped edges
// all occur. Both stream sides idle at random, and once the result side holds
// off long enough for the block to stall its input.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [bet_pkg::ACTION_W-1:0] ACT_NOOP = 2'd3;
  localparam int RANDOM_REQUESTS = 340;
  localparam int CYCLE_LIMIT     = 2_000_000;
  localparam int HOLD_AFTER      = 40;
  localparam int HOLD_CYCLES     = 2500;
  localparam int SETTLE_CYCLES   = 50;

  typedef struct packed {
    logic                          ovf;
    logic [bet_pkg::CNT_OUT_W-1:0] count;
    logic                          valid;
    bet_pkg::vertex_t              second;
    bet_pkg::vertex_t              first;
  } edge_result_t;

  typedef enum {
    K_FRESH, K_REUSE, K_POOL, K_READ, K_CLEAR, K_NOOP, K_NOISE
  } req_kind_t;

  class edge_toggle_checker;
    bet_pkg::vertex_t tab_first [bet_pkg::EDGE_SLOTS];
    bet_pkg::vertex_t tab_second[bet_pkg::EDGE_SLOTS];
    int unsigned      held;
    int unsigned      drops;
    int unsigned      accepted;
    int unsigned      checked;
    int unsigned      mismatches;
    edge_result_t     due_results[$];

    function new();
      held       = 0;
      drops      = 0;
      accepted   = 0;
      checked    = 0;
      mismatches = 0;
    endfunction

    // Removes the first matching edge in either orientation, else appends it if room is left.
    function bit flip_edge(bet_pkg::vertex_t p, bet_pkg::vertex_t q);
      int hit;
      int i;
      hit = -1;
      for (i = 0; i < int'(held); i++) begin
        if (hit < 0 && ((tab_first[i] == p && tab_second[i] == q) ||
                        (tab_first[i] == q && tab_second[i] == p))) begin
          hit = i;
        end
      end
      if (hit >= 0) begin
        for (i = hit; i + 1 < int'(held); i++) begin
          tab_first[i]  = tab_first[i + 1];
          tab_second[i] = tab_second[i + 1];
        end
        held--;
        return 1'b0;
      end
      if (held >= bet_pkg::EDGE_SLOTS) begin
        drops++;
        return 1'b1;
      end
      tab_first[held]  = p;
      tab_second[held] = q;
      held++;
      return 1'b0;
    endfunction

    function void note_request(logic [bet_pkg::ACTION_W-1:0] act,
                               logic [bet_pkg::IN_TDATA_W-1:0] data);
      edge_result_t                  res;
      bet_pkg::vertex_t              a;
      bet_pkg::vertex_t              b;
      bet_pkg::vertex_t              c;
      logic [bet_pkg::INDEX_W-1:0]   idx;
      bit                            lost;
      res  = '0;
      a    = data[0 +: bet_pkg::VERTEX_BITS];
      b    = data[bet_pkg::VERTEX_BITS +: bet_pkg::VERTEX_BITS];
      c    = data[2*bet_pkg::VERTEX_BITS +: bet_pkg::VERTEX_BITS];
      idx  = data[3*bet_pkg::VERTEX_BITS +: bet_pkg::INDEX_W];
      lost = 1'b0;
      accepted++;
      case (act)
        bet_pkg::ACT_UPDATE: begin
          if (flip_edge(a, b)) lost = 1'b1;
          if (flip_edge(b, c)) lost = 1'b1;
          if (flip_edge(c, a)) lost = 1'b1;
          res.ovf = lost;
        end
        bet_pkg::ACT_READ: begin
          if (idx < held) begin
            res.first  = tab_first[idx];
            res.second = tab_second[idx];
            res.valid  = 1'b1;
          end
        end
        bet_pkg::ACT_CLEAR: begin
          held = 0;
        end
        default: begin
        end
      endcase
      res.count = bet_pkg::CNT_OUT_W'(held);
      due_results = {due_results, res};
    endfunction

    function void check_response(logic [bet_pkg::OUT_TDATA_W-1:0] data);
      edge_result_t got;
      edge_result_t want;
      got.first  = data[0 +: bet_pkg::VERTEX_BITS];
      got.second = data[bet_pkg::VERTEX_BITS +: bet_pkg::VERTEX_BITS];
      got.valid  = data[2*bet_pkg::VERTEX_BITS];
      got.count  = data[2*bet_pkg::VERTEX_BITS + 1 +: bet_pkg::CNT_OUT_W];
      got.ovf    = data[2*bet_pkg::VERTEX_BITS + 1 + bet_pkg::CNT_OUT_W];
      checked++;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d arrived with no request outstanding: %h", checked, data);
        return;
      end
      want = due_results.pop_front();
      if (got.first !== want.first || got.second !== want.second ||
          got.valid !== want.valid || got.count !== want.count ||
          got.ovf !== want.ovf) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result %0d expected first=%h second=%h valid=%b count=%0d ovf=%b",
                   checked, want.first, want.second, want.valid, want.count, want.ovf);
          $display("result %0d got      first=%h second=%h valid=%b count=%0d ovf=%b",
                   checked, got.first, got.second, got.valid, got.count, got.ovf);
        end
      end
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [bet_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic [bet_pkg::ACTION_W-1:0]    in_tuser;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [bet_pkg::OUT_TDATA_W-1:0] out_tdata;

  edge_toggle_checker sb = new();
  int unsigned        cycle_cnt = 0;
  int                 burst_left = 0;

  always #6 clk = ~clk;

  boundary_edge_toggle u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1)
      sb.check_response(out_tdata);
  end

  task automatic send_request(input logic [bet_pkg::ACTION_W-1:0] act,
                              input bet_pkg::vertex_t a,
                              input bet_pkg::vertex_t b, input bet_pkg::vertex_t c,
                              input logic [bet_pkg::INDEX_W-1:0] idx);
    logic [bet_pkg::IN_TDATA_W-1:0] word;
    int                             gap;
    word = '0;
    word[0 +: bet_pkg::VERTEX_BITS]                     = a;
    word[bet_pkg::VERTEX_BITS +: bet_pkg::VERTEX_BITS]   = b;
    word[2*bet_pkg::VERTEX_BITS +: bet_pkg::VERTEX_BITS] = c;
    word[3*bet_pkg::VERTEX_BITS +: bet_pkg::INDEX_W]     = idx;
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= word;
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    sb.note_request(act, word);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(0, 12);
    end
  endtask

  initial begin : result_side
    int  mode;
    int  mode_left;
    bit  hold_done;
    mode      = 0;
    mode_left = 0;
    hold_done = 1'b0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && sb.accepted >= HOLD_AFTER) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(2);
          mode_left = $urandom_range(10, 60);
        end
        mode_left--;
        case (mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= 1'($urandom_range(1));
          default: out_tready <= ($urandom_range(3) == 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    bet_pkg::vertex_t             v[3];
    bet_pkg::vertex_t             p;
    bet_pkg::vertex_t             q;
    bet_pkg::vertex_t             r;
    bet_pkg::vertex_t             tmp;
    int                           pick;
    int                           rot;
    int                           k;
    int                           n;
    bit                           filling;
    req_kind_t                    kind;
    logic [bet_pkg::ACTION_W-1:0] act;
    logic [bet_pkg::INDEX_W-1:0]  idx;

    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= bet_pkg::ACT_UPDATE;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(bet_pkg::ACT_READ,   16'h0000, 16'h0000, 16'h0000, 8'h00);
    send_request(ACT_NOOP,            16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_request(bet_pkg::ACT_UPDATE, 16'h0000, 16'hFFFF, 16'h0001, 8'hFF);
    send_request(bet_pkg::ACT_READ,   16'h0000, 16'h0000, 16'h0000, 8'h00);
    send_request(bet_pkg::ACT_READ,   16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h02);
    send_request(bet_pkg::ACT_READ,   16'h0000, 16'h0000, 16'h0000, 8'hFF);
    // The reversed edge must cancel the stored one.
    send_request(bet_pkg::ACT_UPDATE, 16'hFFFF, 16'h0000, 16'h0002, 8'h00);
    send_request(bet_pkg::ACT_UPDATE, 16'h0001, 16'hFFFF, 16'h0000, 8'h00);
    // Degenerate edges toggle like any other.
    send_request(bet_pkg::ACT_UPDATE, 16'h0007, 16'h0007, 16'h0007, 8'h00);
    send_request(bet_pkg::ACT_UPDATE, 16'h0005, 16'h0005, 16'h0009, 8'h00);
    // The same triangle in the opposite winding removes each of its edges.
    send_request(bet_pkg::ACT_UPDATE, 16'h000A, 16'h0014, 16'h001E, 8'h00);
    send_request(bet_pkg::ACT_UPDATE, 16'h001E, 16'h0014, 16'h000A, 8'h00);
    send_request(bet_pkg::ACT_READ,   16'h0000, 16'h0000, 16'h0000, 8'h00);
    send_request(bet_pkg::ACT_READ,   16'h0000, 16'h0000, 16'h0000, 8'h01);
    send_request(bet_pkg::ACT_READ,   16'h0000, 16'h0000, 16'h0000, 8'h03);
    send_request(bet_pkg::ACT_READ,   16'h0000, 16'h0000, 16'h0000, 8'h05);
    send_request(bet_pkg::ACT_CLEAR,  16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_request(bet_pkg::ACT_READ,   16'h0000, 16'h0000, 16'h0000, 8'h00);
    send_request(bet_pkg::ACT_UPDATE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_request(bet_pkg::ACT_READ,   16'h0000, 16'h0000, 16'h0000, 8'h00);
    send_request(bet_pkg::ACT_READ,   16'h0000, 16'h0000, 16'h0000, 8'h01);
    send_request(bet_pkg::ACT_CLEAR,  16'h0000, 16'h0000, 16'h0000, 8'h00);

    n = 0;
    while (n < RANDOM_REQUESTS) begin
      filling = (sb.drops < 6) && (n < 220);
      pick    = $urandom_range(99);
      if (filling) begin
        if (pick < 65)      kind = K_FRESH;
        else if (pick < 78) kind = K_REUSE;
        else if (pick < 83) kind = K_POOL;
        else                kind = K_READ;
      end else begin
        if (pick < 18)      kind = K_FRESH;
        else if (pick < 43) kind = K_REUSE;
        else if (pick < 58) kind = K_POOL;
        else if (pick < 83) kind = K_READ;
        else if (pick < 87) kind = K_CLEAR;
        else if (pick < 90) kind = K_NOOP;
        else                kind = K_NOISE;
      end
      act = bet_pkg::ACT_UPDATE;
      idx = bet_pkg::INDEX_W'($urandom_range(255));
      for (k = 0; k < 3; k++) v[k] = bet_pkg::vertex_t'($urandom_range(65535));
      case (kind)
        K_REUSE: begin
          if (sb.held > 0) begin
            k = $urandom_range(sb.held - 1);
            p = sb.tab_first[k];
            q = sb.tab_second[k];
            if ($urandom_range(1) == 1) begin
              tmp = p;
              p   = q;
              q   = tmp;
            end
            if ($urandom_range(1) == 1)
              r = bet_pkg::vertex_t'($urandom_range(2)) ^
                  ($urandom_range(1) ? 16'hFFFF : 16'h0000);
            else
              r = bet_pkg::vertex_t'($urandom_range(65535));
            rot = $urandom_range(2);
            v[rot]           = q;
            v[(rot + 1) % 3] = p;
            v[(rot + 2) % 3] = r;
          end
        end
        K_POOL: begin
          for (k = 0; k < 3; k++)
            v[k] = bet_pkg::vertex_t'($urandom_range(2)) ^
                   ($urandom_range(1) ? 16'hFFFF : 16'h0000);
        end
        K_READ: begin
          act = bet_pkg::ACT_READ;
          if (sb.held > 0 && $urandom_range(4) != 0)
            idx = bet_pkg::INDEX_W'($urandom_range(sb.held - 1));
        end
        K_CLEAR: act = bet_pkg::ACT_CLEAR;
        K_NOOP:  act = ACT_NOOP;
        K_NOISE: act = bet_pkg::ACTION_W'($urandom_range(3));
        default: begin
        end
      endcase
      send_request(act, v[0], v[1], v[2], idx);
      if (act != ACT_NOOP) n++;
    end

    in_tvalid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.due_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* boundary_edge_toggle.f */
hdl/bet_pkg.sv
hdl/bet_ram.sv
hdl/boundary_edge_toggle.sv
verif/tb_top.sv
